// ===== rtl/fcr_pkg.sv =====
// Shared types, constants and codes for the fully connected ReLU layer.
package fcr_pkg;

    localparam int FEAT_W  = 8;
    localparam int WGT_W   = 8;
    localparam int ACC_W   = 32;
    localparam int PROD_W  = FEAT_W + WGT_W;
    localparam int ADDR_W  = 14;
    localparam int CNT_W   = 15;
    localparam int NCNT_W  = 13;
    localparam int IDX_W   = 12;
    localparam int VALUE_W = 32;
    localparam int RES_W   = 31;
    localparam int CFG_W   = 15;

    localparam logic [CNT_W-1:0]  MAX_FEATURES = 15'd16384;
    localparam logic [NCNT_W-1:0] MAX_NEURONS  = 13'd4096;
    localparam logic [CNT_W-1:0]  RESET_INPUT_LENGTH  = 15'd9216;
    localparam logic [NCNT_W-1:0] RESET_OUTPUT_LENGTH = 13'd4096;

    localparam logic [1:0] REQ_FEATURE = 2'd0;
    localparam logic [1:0] REQ_BIAS    = 2'd1;
    localparam logic [1:0] REQ_WEIGHT  = 2'd2;

    localparam logic CFG_INPUT_LENGTH  = 1'b0;
    localparam logic CFG_OUTPUT_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_FEATURE,
        PH_BIAS,
        PH_WEIGHT
    } phase_t;

    typedef enum logic [1:0] {
        OP_FEATURE,
        OP_BIAS,
        OP_WEIGHT,
        OP_ERROR
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ADDR_W-1:0] addr;
        logic             done;
        logic             last;
        logic [IDX_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [VALUE_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [RES_W-1:0] neuron_value;
        logic [IDX_W-1:0] neuron_index;
        logic             last;
        logic             order_error;
    } result_t;

endpackage

// ===== rtl/fcr_seq.sv =====
// Phase sequencer and counters that decide what each accepted transaction does.
module fcr_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  req_type,
    input  logic [fcr_pkg::CNT_W-1:0]   input_length,
    input  logic [fcr_pkg::NCNT_W-1:0]  output_length,
    output fcr_pkg::cmd_t               cmd
);

    fcr_pkg::phase_t             phase_reg, phase_next;
    logic [fcr_pkg::CNT_W-1:0]   feature_count_reg, feature_count_next;
    logic [fcr_pkg::CNT_W-1:0]   weight_count_reg, weight_count_next;
    logic [fcr_pkg::NCNT_W-1:0]  neuron_count_reg, neuron_count_next;

    logic [fcr_pkg::CNT_W-1:0]   in_len;
    logic [fcr_pkg::NCNT_W-1:0]  out_len;
    logic [fcr_pkg::CNT_W-1:0]   feature_inc;
    logic [fcr_pkg::CNT_W-1:0]   weight_inc;
    logic [fcr_pkg::NCNT_W:0]    neuron_inc;
    logic                        type_ok;
    logic                        features_done;
    logic                        neuron_done;
    logic                        pass_done;

    always_comb
    begin
        if (input_length == '0)
            in_len = fcr_pkg::CNT_W'(1);
        else if (input_length > fcr_pkg::MAX_FEATURES)
            in_len = fcr_pkg::MAX_FEATURES;
        else
            in_len = input_length;

        if (output_length == '0)
            out_len = fcr_pkg::NCNT_W'(1);
        else if (output_length > fcr_pkg::MAX_NEURONS)
            out_len = fcr_pkg::MAX_NEURONS;
        else
            out_len = output_length;

        feature_inc   = feature_count_reg + fcr_pkg::CNT_W'(1);
        weight_inc    = weight_count_reg + fcr_pkg::CNT_W'(1);
        neuron_inc    = {1'b0, neuron_count_reg} + (fcr_pkg::NCNT_W + 1)'(1);
        features_done = feature_inc >= in_len;
        neuron_done   = weight_inc >= in_len;
        pass_done     = neuron_inc >= {1'b0, out_len};

        unique case (phase_reg)
            fcr_pkg::PH_FEATURE: type_ok = req_type == fcr_pkg::REQ_FEATURE;
            fcr_pkg::PH_BIAS:    type_ok = req_type == fcr_pkg::REQ_BIAS;
            fcr_pkg::PH_WEIGHT:  type_ok = req_type == fcr_pkg::REQ_WEIGHT;
            default:             type_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next         = phase_reg;
        feature_count_next = feature_count_reg;
        weight_count_next  = weight_count_reg;
        neuron_count_next  = neuron_count_reg;
        if (accept && type_ok)
        begin
            unique case (phase_reg)
                fcr_pkg::PH_FEATURE:
                begin
                    feature_count_next = feature_inc;
                    if (features_done)
                    begin
                        feature_count_next = '0;
                        neuron_count_next  = '0;
                        phase_next         = fcr_pkg::PH_BIAS;
                    end
                end
                fcr_pkg::PH_BIAS:
                begin
                    weight_count_next = '0;
                    phase_next        = fcr_pkg::PH_WEIGHT;
                end
                fcr_pkg::PH_WEIGHT:
                begin
                    weight_count_next = weight_inc;
                    if (neuron_done)
                    begin
                        weight_count_next = '0;
                        if (pass_done)
                        begin
                            neuron_count_next  = '0;
                            feature_count_next = '0;
                            phase_next         = fcr_pkg::PH_FEATURE;
                        end
                        else
                        begin
                            neuron_count_next = neuron_inc[fcr_pkg::NCNT_W-1:0];
                            phase_next        = fcr_pkg::PH_BIAS;
                        end
                    end
                end
                default:
                begin
                    phase_next = fcr_pkg::PH_FEATURE;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.done  = 1'b0;
        cmd.last  = pass_done;
        cmd.index = neuron_count_reg[fcr_pkg::IDX_W-1:0];
        cmd.addr  = weight_count_reg[fcr_pkg::ADDR_W-1:0];
        if (!type_ok)
            cmd.op = fcr_pkg::OP_ERROR;
        else
        begin
            unique case (phase_reg)
                fcr_pkg::PH_FEATURE:
                begin
                    cmd.op   = fcr_pkg::OP_FEATURE;
                    cmd.addr = feature_count_reg[fcr_pkg::ADDR_W-1:0];
                end
                fcr_pkg::PH_BIAS:
                    cmd.op = fcr_pkg::OP_BIAS;
                fcr_pkg::PH_WEIGHT:
                begin
                    cmd.op   = fcr_pkg::OP_WEIGHT;
                    cmd.done = neuron_done;
                end
                default:
                    cmd.op = fcr_pkg::OP_ERROR;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= fcr_pkg::PH_FEATURE;
            feature_count_reg <= '0;
            weight_count_reg  <= '0;
            neuron_count_reg  <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            feature_count_reg <= feature_count_next;
            weight_count_reg  <= weight_count_next;
            neuron_count_reg  <= neuron_count_next;
        end
    end

endmodule

// ===== rtl/fcr_mac.sv =====
// Feature memory, multiply-accumulate stage and ReLU result forming.
module fcr_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 accept,
    input  fcr_pkg::cmd_t                        cmd,
    input  logic signed [fcr_pkg::VALUE_W-1:0]   value,
    output logic                                 res_valid,
    output fcr_pkg::result_t                     res
);

    logic [fcr_pkg::FEAT_W-1:0]        feature_mem [fcr_pkg::MAX_FEATURES];
    logic [fcr_pkg::FEAT_W-1:0]        feature_reg;
    logic                              s1_valid_reg;
    fcr_pkg::cmd_t                     s1_cmd_reg;
    logic [fcr_pkg::VALUE_W-1:0]       s1_value_reg;
    logic [fcr_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic signed [fcr_pkg::PROD_W-1:0] product;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (cmd.op == fcr_pkg::OP_FEATURE)
                feature_mem[cmd.addr] <= value[fcr_pkg::FEAT_W-1:0];
            feature_reg <= feature_mem[cmd.addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= cmd;
            s1_value_reg <= value;
        end
    end

    assign product = $signed(s1_value_reg[fcr_pkg::WGT_W-1:0]) * $signed(feature_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (s1_cmd_reg.op == fcr_pkg::OP_BIAS)
            acc_next = s1_value_reg;
        else if (s1_cmd_reg.op == fcr_pkg::OP_WEIGHT)
            acc_next = acc_reg + {{(fcr_pkg::ACC_W - fcr_pkg::PROD_W){product[fcr_pkg::PROD_W-1]}},
                                  product};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else if (advance && s1_valid_reg)
            acc_reg <= acc_next;
    end

    always_comb
    begin
        res = '0;
        res_valid = 1'b0;
        if (s1_cmd_reg.op == fcr_pkg::OP_ERROR)
        begin
            res_valid       = s1_valid_reg;
            res.order_error = 1'b1;
        end
        else if (s1_cmd_reg.op == fcr_pkg::OP_WEIGHT && s1_cmd_reg.done)
        begin
            res_valid        = s1_valid_reg;
            res.neuron_value = acc_next[fcr_pkg::ACC_W-1] ? '0 : acc_next[fcr_pkg::RES_W-1:0];
            res.neuron_index = s1_cmd_reg.index;
            res.last         = s1_cmd_reg.last;
        end
    end

endmodule

// ===== rtl/fully_connected_relu_layer_top.sv =====
// Top level of the fully connected ReLU layer: configuration, handshake and result register.
//
// The layer takes one transaction per clock cycle while item_stall is low. A
// pass first loads input_length features, then for every neuron one bias and
// input_length weights, and each neuron yields one result; a transaction of the
// wrong kind is dropped and answered with an error result. An accepted
// transaction passes through the stage-1 registers, which hold the registered
// read of the feature memory, and then through the multiply-accumulate into
// the result register, from which its result leaves. The single-port feature
// memory with its registered read and the one multiply-accumulate unit set
// this one-transaction-per-cycle rate. Input stall is raised only while a
// result is held by the downstream stall.
module fully_connected_relu_layer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  fcr_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output fcr_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fcr_pkg::CFG_W-1:0]     cfg_data
);

    logic [fcr_pkg::CNT_W-1:0]  input_length_reg;
    logic [fcr_pkg::NCNT_W-1:0] output_length_reg;
    logic                       result_valid_reg;
    fcr_pkg::result_t           result_reg;
    logic                       advance;
    logic                       accept;
    fcr_pkg::cmd_t              cmd;
    logic                       res_valid;
    fcr_pkg::result_t           res;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;
    assign accept     = item_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_length_reg  <= fcr_pkg::RESET_INPUT_LENGTH;
            output_length_reg <= fcr_pkg::RESET_OUTPUT_LENGTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fcr_pkg::CFG_INPUT_LENGTH:  input_length_reg <= cfg_data;
                fcr_pkg::CFG_OUTPUT_LENGTH: output_length_reg <= cfg_data[fcr_pkg::NCNT_W-1:0];
                default:                    input_length_reg <= input_length_reg;
            endcase
        end
    end

    fcr_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .req_type      (item.req_type),
        .input_length  (input_length_reg),
        .output_length (output_length_reg),
        .cmd           (cmd)
    );

    fcr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .accept    (accept),
        .cmd       (cmd),
        .value     (item.value),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            result_reg <= res;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/fcr_checker.sv =====
// Port-level checker for the fully connected ReLU layer and its bind statement.
module fcr_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_stall,
    input  logic                 result_valid,
    input  logic                 result_stall,
    input  fcr_pkg::result_t     result
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("Stalled result transaction changed.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("Input stalled without a held result transaction.");

    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.order_error |->
            result.neuron_value == '0 && result.neuron_index == '0 && !result.last)
        else $error("Error result carries nonzero fields.");

    a_last_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !result.order_error)
        else $error("Final neuron result flagged as an error.");

endmodule

bind fully_connected_relu_layer_top fcr_checker u_fcr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
